// File: rtl/core/tef_pkg.sv
// Package for the tensor element to fp32 converter.
// Holds element type codes, field constants and the stage payload structs.
package tef_pkg;

  typedef enum logic [2:0] {
    TYPE_FP32  = 3'd0,
    TYPE_FP16  = 3'd1,
    TYPE_INT8  = 3'd2,
    TYPE_INT32 = 3'd3
  } elem_type_e;

  localparam logic [4:0] HalfExpAll   = 5'h1f;
  localparam logic [7:0] ExpRebias    = 8'd112;
  localparam logic [7:0] Fp32ExpAll   = 8'hff;
  localparam logic [7:0] IntExpBase   = 8'd126;

  // Stage 1 -> 2: decoded operand as sign and magnitude.
  typedef struct packed {
    logic        is_int;
    logic        sign;
    logic [31:0] mag;      // integer magnitude, or preformed float bits
    logic        bad;
    logic        last;
  } s1_t;

  // Stage 2 -> 3: normalized integer or final float.
  typedef struct packed {
    logic        is_int;
    logic        sign;
    logic [31:0] norm;     // integer magnitude with the leading one at bit 31, or float bits
    logic [4:0]  pos;      // leading one position
    logic        zero;
    logic        bad;
    logic        last;
  } s2_t;

  // Leading one position of a nonzero word.
  function automatic logic [4:0] lead_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// File: rtl/core/tef_decode.sv
// Stage 1: type decode, half widening and integer sign/magnitude.
// Depends on tef_pkg.
module tef_decode import tef_pkg::*; (
  input  logic [2:0]  elem_type_i,
  input  logic [31:0] raw_word_i,
  input  logic        last_i,
  output s1_t         s1_o
);
  logic [4:0]  he;
  logic [9:0]  hm;
  logic [4:0]  k;
  logic [9:0]  hn;
  logic [31:0] half_bits;
  logic [7:0]  ib;

  always_comb begin
    he = raw_word_i[14:10];
    hm = raw_word_i[9:0];
    k  = lead_pos({22'd0, hm});
    hn = 10'(hm << (5'd10 - k));
    if (he == '0) begin
      if (hm == '0) half_bits = {raw_word_i[15], 31'd0};
      else half_bits = {raw_word_i[15], 8'(8'd103 + {3'd0, k}), hn, 13'd0};
    end else if (he == HalfExpAll) begin
      half_bits = {raw_word_i[15], Fp32ExpAll, hm, 13'd0};
    end else begin
      half_bits = {raw_word_i[15], 8'({3'd0, he} + ExpRebias), hm, 13'd0};
    end
    ib = raw_word_i[7:0];
    s1_o = '0;
    s1_o.last = last_i;
    case (elem_type_i)
      TYPE_FP32: s1_o.mag = raw_word_i;
      TYPE_FP16: s1_o.mag = half_bits;
      TYPE_INT8: begin
        s1_o.is_int = 1'b1;
        s1_o.sign   = ib[7];
        s1_o.mag    = {24'd0, ib[7] ? 8'(8'd0 - ib) : ib};
      end
      TYPE_INT32: begin
        s1_o.is_int = 1'b1;
        s1_o.sign   = raw_word_i[31];
        s1_o.mag    = raw_word_i[31] ? 32'(32'd0 - raw_word_i) : raw_word_i;
      end
      default: s1_o.bad = 1'b1;
    endcase
  end
endmodule

// File: rtl/core/tef_normalize.sv
// Stage 2: leading one count and normalizing shift.
// Depends on tef_pkg.
module tef_normalize import tef_pkg::*; (
  input  s1_t s1_i,
  output s2_t s2_o
);
  logic [4:0] p;
  always_comb begin
    p = lead_pos(s1_i.mag);
    s2_o.is_int = s1_i.is_int;
    s2_o.sign   = s1_i.sign;
    s2_o.pos    = p;
    s2_o.zero   = (s1_i.mag == '0);
    s2_o.bad    = s1_i.bad;
    s2_o.last   = s1_i.last;
    s2_o.norm   = s1_i.is_int ? 32'(s1_i.mag << (5'd31 - p)) : s1_i.mag;
  end
endmodule

// File: rtl/core/tef_round.sv
// Stage 3: round to nearest even and pack the float.
// Depends on tef_pkg.
module tef_round import tef_pkg::*; (
  input  s2_t         s2_i,
  output logic [31:0] fp32_bits_o
);
  logic [23:0] mant;
  logic        g, st, up;
  logic [31:0] base;
  always_comb begin
    mant = s2_i.norm[31:8];
    g    = s2_i.norm[7];
    st   = |s2_i.norm[6:0];
    up   = g & (st | mant[0]);
    base = {s2_i.sign, 8'(IntExpBase + {3'd0, s2_i.pos}), 23'd0};
    if (s2_i.bad || (s2_i.is_int && s2_i.zero)) fp32_bits_o = '0;
    else if (!s2_i.is_int) fp32_bits_o = s2_i.norm;
    else fp32_bits_o = 32'(base + {8'd0, mant} + {31'd0, up});
  end
endmodule

// File: rtl/core/tensor_element_to_fp32.sv
// Top level of the tensor element to fp32 converter.
// Depends on tef_pkg, tef_decode, tef_normalize, tef_round.
//
// Usage: one element per beat on the s_axis channel, one fp32 result per
// beat on the m_axis channel, in order. s_axis_tdata carries raw_word in
// bits 31:0; s_axis_tuser carries elem_type; tlast marks the final element.
// m_axis_tdata carries fp32_bits; m_axis_tuser carries bad_type.
// Pipeline: decode, normalize, round, each followed by a register stage;
// an accepted element passes s1_q, s2_q and out_q before m_axis_tvalid.
// Throughput: one element per cycle unless stalled; every stage advances
// when the stage after it is empty or being drained, so a stalled receiver
// only freezes the occupied stages and a bubble is filled in the same cycle.
// Reset clears all valid bits; nothing is in flight afterward.
// When m_axis_tready is low the output holds; s_axis_tready drops only
// once all three stages are full.
module tensor_element_to_fp32 import tef_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // raw_word[31:0]
  input  logic [2:0]  s_axis_tuser,   // elem_type[2:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // fp32_bits[31:0]
  output logic        m_axis_tuser,   // bad_type
  output logic        m_axis_tlast
);
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  logic [31:0] out_d, out_q;
  logic bad_q, last_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  tef_decode u_dec (
    .elem_type_i(s_axis_tuser), .raw_word_i(s_axis_tdata),
    .last_i(s_axis_tlast), .s1_o(s1_d)
  );
  tef_normalize u_norm (.s1_i(s1_q), .s2_o(s2_d));
  tef_round u_rnd (.s2_i(s2_q), .fp32_bits_o(out_d));

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) begin
      out_q  <= out_d;
      bad_q  <= s2_q.bad;
      last_q <= s2_q.last;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = bad_q;
  assign m_axis_tlast  = last_q;
endmodule

// File: rtl/core/tef_checker.sv
// Port checker for the converter, bound to the top level.
// Depends on tensor_element_to_fp32 ports only.
module tef_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  // A stalled result holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  // An unsupported type always reads as zero
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("bad type with nonzero data");
  // Input is ready whenever the output side drains
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output drains");
  // An accepted beat reaches m_axis_tvalid through the stages while the receiver stays ready
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
    ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after three cycles");
endmodule

bind tensor_element_to_fp32 tef_checker u_tef_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// File: test/tb.sv
// Testbench for tensor_element_to_fp32: drives elements on the input stream and checks
// every output beat against a local conversion model. Depends on tef_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tef_pkg::*;

  typedef struct {
    logic [31:0] bits;
    logic        bad;
    logic        last;
  } fp32_res_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] word;
    logic        last;
    logic        known;   // expected value typed in below
    logic [31:0] bits;
    logic        bad;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  fp32_res_t   expected_q[$];
  int          n_errors;
  int          idle_cycles;
  bit          stim_done;
  bit          hold_done;

  localparam logic [2:0] TypeBad4 = 3'd4;
  localparam logic [2:0] TypeBad5 = 3'd5;
  localparam logic [2:0] TypeBad6 = 3'd6;
  localparam logic [2:0] TypeBad7 = 3'd7;
  localparam int         WatchdogLimit = 5000;

  tensor_element_to_fp32 DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sign and magnitude to single precision, round to nearest even.
  function automatic logic [31:0] int_mag_to_fp32(logic sgn, logic [31:0] mag);
    int          msb;
    int          sh;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    msb = 0;
    if (mag == '0) return '0;
    for (int i = 0; i < 32; i++) if (mag[i]) msb = i;
    if (msb <= 23) begin
      mant = mag << (23 - msb);
    end else begin
      sh   = msb - 23;
      rem  = mag & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      mant = mag >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
    end
    // rounding carry into bit 24 bumps the exponent through the add
    return ({sgn, 31'd0}) + ((32'd126 + 32'(msb)) << 23) + mant;
  endfunction

  function automatic logic [31:0] half_to_fp32(logic [15:0] h);
    logic [7:0] ex;
    logic [9:0] fr;
    logic [10:0] m;
    ex = 8'(h[14:10]);
    fr = h[9:0];
    if (ex == 0) begin
      if (fr == 0) return {h[15], 31'd0};
      // normalize subnormal
      m  = {1'b0, fr};
      ex = 8'd113;
      while (!m[10]) begin
        m  = m << 1;
        ex = ex - 1;
      end
      return {h[15], ex, m[9:0], 13'd0};
    end
    if (h[14:10] == HalfExpAll) return {h[15], Fp32ExpAll, fr, 13'd0};
    return {h[15], ex + ExpRebias, fr, 13'd0};
  endfunction

  function automatic fp32_res_t convert_element(logic [2:0] kind, logic [31:0] w,
                                                logic lst);
    fp32_res_t r;
    r.bad  = 1'b0;
    r.last = lst;
    r.bits = '0;
    case (kind)
      TYPE_FP32:  r.bits = w;
      TYPE_FP16:  r.bits = half_to_fp32(w[15:0]);
      TYPE_INT8:  r.bits = int_mag_to_fp32(w[7], w[7] ? 32'(8'(-w[7:0])) : 32'(w[7:0]));
      TYPE_INT32: r.bits = int_mag_to_fp32(w[31], w[31] ? -w : w);
      default:    r.bad  = 1'b1;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Offer one element, hold it until accepted.
  task automatic send_element(logic [2:0] kind, logic [31:0] w, logic lst);
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= w;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q = {expected_q, convert_element(kind, w, lst)};
    @(negedge clk_i);
  endtask

  // Directed table: extremes of every type and the named special cases.
  stim_row_t dir_table[] = '{
    '{TYPE_FP32,  32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{TYPE_FP32,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{TYPE_FP16,  32'hABCD_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{TYPE_FP16,  32'h0000_8000, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
    '{TYPE_FP16,  32'h0000_0001, 1'b0, 1'b1, 32'h3380_0000, 1'b0},
    '{TYPE_FP16,  32'h0000_03FF, 1'b0, 0, '0, 0},
    '{TYPE_FP16,  32'hFFFF_8200, 1'b0, 0, '0, 0},
    '{TYPE_FP16,  32'h0000_7C00, 1'b0, 1'b1, 32'h7F80_0000, 1'b0},
    '{TYPE_FP16,  32'h0000_FE01, 1'b0, 1'b1, 32'hFFC0_2000, 1'b0},
    '{TYPE_FP16,  32'h0000_3C00, 1'b1, 1'b1, 32'h3F80_0000, 1'b0},
    '{TYPE_FP16,  32'h0000_7BFF, 1'b0, 0, '0, 0},
    '{TYPE_INT8,  32'hFFFF_FF00, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{TYPE_INT8,  32'h0000_007F, 1'b0, 1'b1, 32'h42FE_0000, 1'b0},
    '{TYPE_INT8,  32'h0000_0080, 1'b0, 1'b1, 32'hC300_0000, 1'b0},
    '{TYPE_INT8,  32'hFFFF_FFFF, 1'b0, 1'b1, 32'hBF80_0000, 1'b0},
    '{TYPE_INT32, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{TYPE_INT32, 32'h8000_0000, 1'b0, 1'b1, 32'hCF00_0000, 1'b0},
    '{TYPE_INT32, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h4F00_0000, 1'b0},
    '{TYPE_INT32, 32'h0100_0001, 1'b0, 0, '0, 0},
    '{TYPE_INT32, 32'h0100_0003, 1'b0, 0, '0, 0},
    '{TYPE_INT32, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hBF80_0000, 1'b0},
    '{TypeBad4,   32'h1234_5678, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
    '{TypeBad5,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
    '{TypeBad6,   32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
    '{TypeBad7,   32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1}
  };

  // Drive stimulus.
  initial begin
    fp32_res_t   r;
    logic [2:0]  kind;
    logic [31:0] w;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    n_errors      = 0;
    stim_done     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_table[i]) begin
      // typed-in rows must agree with the model as well
      if (dir_table[i].known) begin
        r = convert_element(dir_table[i].kind, dir_table[i].word, dir_table[i].last);
        if (r.bits !== dir_table[i].bits || r.bad !== dir_table[i].bad)
          report_mismatch("table row", r.bits, dir_table[i].bits);
      end
      send_element(dir_table[i].kind, dir_table[i].word, dir_table[i].last);
    end
    for (int n = 0; n < 1550; n++) begin
      kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      w = $urandom();
      // bias integers toward short magnitudes and halves toward zero and all-ones exponents
      if (kind == TYPE_INT32 && $urandom_range(0, 2) == 0)
        w = w >> $urandom_range(0, 31);
      if (kind == TYPE_FP16 && $urandom_range(0, 3) == 0)
        w[14:10] = ($urandom_range(0, 1) == 0) ? 5'd0 : HalfExpAll;
      send_element(kind, w, 1'($urandom_range(0, 1)));
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off to fill the pipeline.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && expected_q.size() > 1) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_done = 1'b1;
      end
      stall = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
              ($urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0);
      if ($urandom_range(0, 1) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Check each output beat against the oldest expectation.
  always @(posedge clk_i) begin
    fp32_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, '0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata !== want.bits) report_mismatch("fp32_bits", m_axis_tdata, want.bits);
        if (m_axis_tuser !== want.bad)  report_mismatch("bad_type", 32'(m_axis_tuser), 32'(want.bad));
        if (m_axis_tlast !== want.last) report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (stim_done && expected_q.size() == 0) break;
    end
    repeat (20) @(posedge clk_i);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: tensor_element_to_fp32.f
rtl/core/tef_pkg.sv
rtl/core/tef_decode.sv
rtl/core/tef_normalize.sv
rtl/core/tef_round.sv
rtl/core/tensor_element_to_fp32.sv
rtl/core/tef_checker.sv
test/tb.sv
